[hw/rtl/vva_pkg.sv]
// ----------------------------------------------------------------------------
// vva_pkg
// Shared types, opcodes and saturation helpers for the vector ALU.
// ----------------------------------------------------------------------------
package vva_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned EPS_W     = 17;
  localparam int unsigned SATW      = 68;
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned SQ_STAGES = 32;

  localparam logic [EPS_W-1:0] EPS_RESET = 17'd1;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_MIN   = 4'd4;
  localparam logic [3:0] OP_MAX   = 4'd5;
  localparam logic [3:0] OP_CEIL  = 4'd6;
  localparam logic [3:0] OP_FLOOR = 4'd7;
  localparam logic [3:0] OP_CROSS = 4'd8;
  localparam logic [3:0] OP_DOT   = 4'd9;
  localparam logic [3:0] OP_LEN   = 4'd10;
  localparam logic [3:0] OP_NORM  = 4'd11;
  localparam logic [3:0] OP_EQ    = 4'd12;
  localparam logic [3:0] OP_AEQ   = 4'd13;

  localparam logic signed [DW-1:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] MIN32 = 32'sh8000_0000;

  // per-component findings of one lane
  typedef struct packed {
    logic [DW-1:0] res;
    logic          sat;
    logic          eq;
    logic          a_neg;
    logic          a_zero;
    logic          b_neg;
    logic          b_zero;
    logic [DW-1:0] amag;
    logic [DW-1:0] bmag;
  } lane_out_t;

  // everything a request carries past the lanes
  typedef struct packed {
    logic [3:0]           op;
    lane_out_t [2:0]      lane;
    logic [DW-1:0]        dot;
    logic                 dot_sat;
  } ctx_t;

  function automatic logic ovf32(input logic signed [SATW-1:0] v);
    return (v > SATW'(MAX32)) || (v < SATW'(MIN32));
  endfunction

  function automatic logic [DW-1:0] clip32(input logic signed [SATW-1:0] v);
    logic [DW-1:0] r;
    if (v > SATW'(MAX32)) begin
      r = MAX32;
    end else if (v < SATW'(MIN32)) begin
      r = MIN32;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/vva_in_if.sv]
// ----------------------------------------------------------------------------
// vva_in_if
// Request channel: opcode and two three-component vectors.
// ----------------------------------------------------------------------------
interface vva_in_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        op;
  logic signed [vva_pkg::DW-1:0]     a_x;
  logic signed [vva_pkg::DW-1:0]     a_y;
  logic signed [vva_pkg::DW-1:0]     a_z;
  logic signed [vva_pkg::DW-1:0]     b_x;
  logic signed [vva_pkg::DW-1:0]     b_y;
  logic signed [vva_pkg::DW-1:0]     b_z;

  modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

[hw/rtl/vva_out_if.sv]
// ----------------------------------------------------------------------------
// vva_out_if
// Result channel: vector, scalar and status flags.
// ----------------------------------------------------------------------------
interface vva_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vva_pkg::DW-1:0]     res_x;
  logic signed [vva_pkg::DW-1:0]     res_y;
  logic signed [vva_pkg::DW-1:0]     res_z;
  logic signed [vva_pkg::DW-1:0]     scalar;
  logic                              is_equal;
  logic                              div_zero;
  logic                              saturated;

  modport source (output valid, res_x, res_y, res_z, scalar, is_equal, div_zero,
                  saturated, input ready);
  modport sink   (input valid, res_x, res_y, res_z, scalar, is_equal, div_zero,
                  saturated, output ready);
endinterface

[hw/rtl/vva_lane.sv]
// ----------------------------------------------------------------------------
// vva_lane
// One component lane: products, elementwise ops and tolerance compare.
// ----------------------------------------------------------------------------
module vva_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [3:0]                    op,
  input  logic [vva_pkg::EPS_W-1:0]     eps,
  input  logic signed [vva_pkg::DW-1:0] a,
  input  logic signed [vva_pkg::DW-1:0] b,
  input  logic signed [vva_pkg::DW-1:0] cx0,
  input  logic signed [vva_pkg::DW-1:0] cx1,
  input  logic signed [vva_pkg::DW-1:0] cx2,
  input  logic signed [vva_pkg::DW-1:0] cx3,
  output logic signed [63:0]            prod_r,
  output vva_pkg::lane_out_t            lane_r
);

  localparam logic [32:0] LOW_MASK = 33'((34'd1 << FRAC_BITS) - 34'd1);
  localparam logic [31:0] ONE_Q    = 32'(33'd1 << FRAC_BITS);
  localparam int          TOL_W    = vva_pkg::EPS_W + 32;

  // first stage registers
  logic signed [63:0] crs_a_r, crs_b_r;
  logic [31:0]        simp_r;
  logic               simp_sat_r;
  logic [32:0]        dif_r;
  logic [TOL_W-1:0]   tol_r;
  logic               same_r;
  logic [3:0]         op_r;
  logic [31:0]        amag_r, bmag_r;
  logic               a_neg_r, a_zero_r, b_neg_r, b_zero_r;

  logic signed [31:0] bm;
  logic signed [32:0] sum_v, dif_v, ceil_v;
  logic [31:0]        simp_nxt;
  logic               simp_sat_nxt;
  logic [31:0]        amag, bmag, mx;
  logic [32:0]        adif;

  always_comb begin
    bm     = (op == vva_pkg::OP_LEN || op == vva_pkg::OP_NORM) ? a : b;
    sum_v  = 33'(a) + 33'(b);
    dif_v  = 33'(a) - 33'(b);
    ceil_v = (33'(a) + $signed(LOW_MASK)) & $signed(~LOW_MASK);
    simp_nxt     = '0;
    simp_sat_nxt = 1'b0;
    unique case (op)
      vva_pkg::OP_ADD: begin
        simp_nxt     = vva_pkg::clip32(vva_pkg::SATW'(sum_v));
        simp_sat_nxt = vva_pkg::ovf32(vva_pkg::SATW'(sum_v));
      end
      vva_pkg::OP_SUB: begin
        simp_nxt     = vva_pkg::clip32(vva_pkg::SATW'(dif_v));
        simp_sat_nxt = vva_pkg::ovf32(vva_pkg::SATW'(dif_v));
      end
      vva_pkg::OP_MIN:   simp_nxt = (a < b) ? a : b;
      vva_pkg::OP_MAX:   simp_nxt = (a > b) ? a : b;
      vva_pkg::OP_CEIL: begin
        simp_nxt     = vva_pkg::clip32(vva_pkg::SATW'(ceil_v));
        simp_sat_nxt = vva_pkg::ovf32(vva_pkg::SATW'(ceil_v));
      end
      vva_pkg::OP_FLOOR: simp_nxt = a & ~LOW_MASK[31:0];
      default:           simp_nxt = '0;
    endcase
    amag = a[31] ? 32'(-a) : 32'(a);
    bmag = b[31] ? 32'(-b) : 32'(b);
    adif = dif_v[32] ? 33'(-dif_v) : 33'(dif_v);
    mx   = ONE_Q;
    if (amag > mx) begin
      mx = amag;
    end
    if (bmag > mx) begin
      mx = bmag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= a * bm;
      crs_a_r    <= cx0 * cx1;
      crs_b_r    <= cx2 * cx3;
      simp_r     <= simp_nxt;
      simp_sat_r <= simp_sat_nxt;
      dif_r      <= adif;
      tol_r      <= TOL_W'(eps) * TOL_W'(mx);
      same_r     <= (a == b);
      op_r       <= op;
      amag_r     <= amag;
      bmag_r     <= bmag;
      a_neg_r    <= a[31];
      a_zero_r   <= (a == '0);
      b_neg_r    <= b[31];
      b_zero_r   <= (b == '0);
    end
  end

  // second stage: scale products back and clip
  logic signed [63:0] mul_v;
  logic signed [64:0] crs_v;
  vva_pkg::lane_out_t lane_nxt;

  always_comb begin
    mul_v = prod_r >>> FRAC_BITS;
    crs_v = (65'(crs_a_r) - 65'(crs_b_r)) >>> FRAC_BITS;
    lane_nxt.res    = simp_r;
    lane_nxt.sat    = simp_sat_r;
    lane_nxt.a_neg  = a_neg_r;
    lane_nxt.a_zero = a_zero_r;
    lane_nxt.b_neg  = b_neg_r;
    lane_nxt.b_zero = b_zero_r;
    lane_nxt.amag   = amag_r;
    lane_nxt.bmag   = bmag_r;
    if (op_r == vva_pkg::OP_MUL) begin
      lane_nxt.res = vva_pkg::clip32(vva_pkg::SATW'(mul_v));
      lane_nxt.sat = vva_pkg::ovf32(vva_pkg::SATW'(mul_v));
    end else if (op_r == vva_pkg::OP_CROSS) begin
      lane_nxt.res = vva_pkg::clip32(vva_pkg::SATW'(crs_v));
      lane_nxt.sat = vva_pkg::ovf32(vva_pkg::SATW'(crs_v));
    end
    if (op_r == vva_pkg::OP_EQ) begin
      lane_nxt.eq = same_r;
    end else begin
      lane_nxt.eq = ((64'(dif_r) << FRAC_BITS) <= 64'(tol_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

[hw/rtl/vva_sqrt.sv]
// ----------------------------------------------------------------------------
// vva_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vva_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vva_pkg::RAD_W-1:0]   rad,
  output logic [31:0]                 root
);

  localparam int N = vva_pkg::SQ_STAGES;
  localparam int W = vva_pkg::RAD_W;

  logic [W-1:0] rem_r  [N];
  logic [W-1:0] res_r  [N];
  logic [W-1:0] rem_nxt[N];
  logic [W-1:0] res_nxt[N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [W-1:0] n_in, r_in, bit_v;
      n_in  = (k == 0) ? rad : rem_r[(k == 0) ? 0 : k - 1];
      r_in  = (k == 0) ? '0  : res_r[(k == 0) ? 0 : k - 1];
      bit_v = W'(1) << (W - 2 - 2 * k);
      if (n_in >= r_in + bit_v) begin
        rem_nxt[k] = n_in - (r_in + bit_v);
        res_nxt[k] = (r_in >> 1) + bit_v;
      end else begin
        rem_nxt[k] = n_in;
        res_nxt[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[N-1][31:0];

endmodule

[hw/rtl/vva_div.sv]
// ----------------------------------------------------------------------------
// vva_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vva_div #(
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] dvd,
  input  logic [31:0]   dvs,
  output logic [QW-1:0] quo
);

  logic [QW-1:0] dvd_r  [QW];
  logic [31:0]   rem_r  [QW];
  logic [31:0]   dvs_r  [QW];
  logic [QW-1:0] dvd_nxt[QW];
  logic [31:0]   rem_nxt[QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      logic [QW-1:0] d_in;
      logic [31:0]   r_in, s_in;
      logic [32:0]   t;
      logic          ge;
      d_in = (k == 0) ? dvd : dvd_r[(k == 0) ? 0 : k - 1];
      r_in = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k - 1];
      s_in = (k == 0) ? dvs : dvs_r[(k == 0) ? 0 : k - 1];
      t    = {r_in, d_in[QW-1]};
      ge   = (t >= {1'b0, s_in});
      rem_nxt[k] = ge ? 32'(t - {1'b0, s_in}) : t[31:0];
      dvd_nxt[k] = {d_in[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        dvd_r[k] <= dvd_nxt[k];
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= (k == 0) ? dvs : dvs_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign quo = dvd_r[QW-1];

endmodule

[hw/rtl/vec3_vector_alu_core.sv]
// ----------------------------------------------------------------------------
// vec3_vector_alu_core
// Three-lane fixed-point vector ALU with pipelined root and divide.
// ----------------------------------------------------------------------------
// Accepts one request per cycle and returns one result per request, in order.
// Every request runs the same pipeline from acceptance to the result register:
// the input register and the lane stages, a 32-stage bit-per-stage square
// root, then a (32 + FRAC_BITS)-stage bit-per-stage divider per lane, then the
// output register. The whole pipeline holds while a result waits unread, so
// in_ready follows out_ready whenever the output register is occupied.
// epsilon is written through cfg_we / cfg_wdata and resets to 1.
module vec3_vector_alu_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vva_pkg::EPS_W-1:0]     cfg_wdata,
  vva_in_if.sink                        in_ch,
  vva_out_if.source                     out_ch
);

  localparam int QW        = 32 + FRAC_BITS;
  localparam int SQ        = vva_pkg::SQ_STAGES;
  localparam int CTX_DEPTH = SQ + QW;

  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // configuration
  logic [vva_pkg::EPS_W-1:0] eps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= vva_pkg::EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // input register
  logic               vld_s1_r, vld_s2_r, vld_s3_r;
  logic [3:0]         op_s1_r, op_s2_r, op_s3_r;
  logic signed [31:0] a_s1_r [3];
  logic signed [31:0] b_s1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      vld_s3_r <= 1'b0;
    end else if (adv) begin
      vld_s1_r <= in_ch.valid;
      vld_s2_r <= vld_s1_r;
      vld_s3_r <= vld_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_s1_r   <= in_ch.op;
      a_s1_r[0] <= in_ch.a_x;
      a_s1_r[1] <= in_ch.a_y;
      a_s1_r[2] <= in_ch.a_z;
      b_s1_r[0] <= in_ch.b_x;
      b_s1_r[1] <= in_ch.b_y;
      b_s1_r[2] <= in_ch.b_z;
      op_s2_r   <= op_s1_r;
      op_s3_r   <= op_s2_r;
    end
  end

  // lanes
  logic signed [63:0] prod [3];
  vva_pkg::lane_out_t lane_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vva_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (adv),
      .op     (op_s1_r),
      .eps    (eps_r),
      .a      (a_s1_r[i]),
      .b      (b_s1_r[i]),
      .cx0    (a_s1_r[(i + 1) % 3]),
      .cx1    (b_s1_r[(i + 2) % 3]),
      .cx2    (a_s1_r[(i + 2) % 3]),
      .cx3    (b_s1_r[(i + 1) % 3]),
      .prod_r (prod[i]),
      .lane_r (lane_q[i])
    );
  end

  // merge of lane products: dot and squared length
  logic [31:0]        dot_r;
  logic               dot_sat_r;
  logic [63:0]        sq_sum_r;
  logic signed [65:0] dot_v;

  assign dot_v = (66'(prod[0]) + 66'(prod[1]) + 66'(prod[2])) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r     <= vva_pkg::clip32(vva_pkg::SATW'(dot_v));
      dot_sat_r <= vva_pkg::ovf32(vva_pkg::SATW'(dot_v));
      sq_sum_r  <= 64'(prod[0]) + 64'(prod[1]) + 64'(prod[2]);
    end
  end

  vva_pkg::ctx_t ctx_s3;
  always_comb begin
    ctx_s3.op      = op_s3_r;
    ctx_s3.lane[0] = lane_q[0];
    ctx_s3.lane[1] = lane_q[1];
    ctx_s3.lane[2] = lane_q[2];
    ctx_s3.dot     = dot_r;
    ctx_s3.dot_sat = dot_sat_r;
  end

  // request context rides alongside root and divider
  vva_pkg::ctx_t          ctx_dl_r [CTX_DEPTH];
  logic [CTX_DEPTH-1:0]   vld_dl_r;
  logic [31:0]            len_dl_r [QW];
  logic [31:0]            root;

  vva_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sq_sum_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_dl_r <= '0;
    end else if (adv) begin
      vld_dl_r <= {vld_dl_r[CTX_DEPTH-2:0], vld_s3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_dl_r[0] <= ctx_s3;
      for (int k = 1; k < CTX_DEPTH; k++) begin
        ctx_dl_r[k] <= ctx_dl_r[k-1];
      end
      len_dl_r[0] <= root;
      for (int k = 1; k < QW; k++) begin
        len_dl_r[k] <= len_dl_r[k-1];
      end
    end
  end

  vva_pkg::ctx_t ctx_sq;
  logic [QW-1:0] quo [3];
  assign ctx_sq = ctx_dl_r[SQ-1];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [31:0] dvs;
    assign dvs = (ctx_sq.op == vva_pkg::OP_NORM) ? root : ctx_sq.lane[i].bmag;
    vva_div #(.QW(QW)) u_div (
      .clk (clk),
      .en  (adv),
      .dvd (QW'(ctx_sq.lane[i].amag) << FRAC_BITS),
      .dvs (dvs),
      .quo (quo[i])
    );
  end

  // final selection
  vva_pkg::ctx_t ctx_end;
  logic [31:0]   len_end;
  logic [31:0]   res_nxt [3];
  logic [31:0]   scalar_nxt;
  logic          eq_nxt, dz_nxt, sat_nxt;

  assign ctx_end = ctx_dl_r[CTX_DEPTH-1];
  assign len_end = len_dl_r[QW-1];

  always_comb begin
    dz_nxt     = 1'b0;
    sat_nxt    = 1'b0;
    scalar_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      logic            neg;
      logic signed [QW:0] qs;
      vva_pkg::lane_out_t ln;
      ln  = ctx_end.lane[i];
      neg = ln.a_neg ^ ((ctx_end.op == vva_pkg::OP_DIV) & ln.b_neg);
      qs  = neg ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      unique case (ctx_end.op)
        vva_pkg::OP_DIV: begin
          if (ln.b_zero) begin
            dz_nxt     = 1'b1;
            res_nxt[i] = ln.a_neg ? vva_pkg::MIN32 : (ln.a_zero ? '0 : vva_pkg::MAX32);
          end else begin
            res_nxt[i] = vva_pkg::clip32(vva_pkg::SATW'(qs));
            sat_nxt    = sat_nxt | vva_pkg::ovf32(vva_pkg::SATW'(qs));
          end
        end
        vva_pkg::OP_NORM: begin
          res_nxt[i] = (len_end == '0) ? '0 : vva_pkg::clip32(vva_pkg::SATW'(qs));
        end
        default: begin
          res_nxt[i] = ln.res;
          sat_nxt    = sat_nxt | ln.sat;
        end
      endcase
    end
    unique case (ctx_end.op)
      vva_pkg::OP_DOT: begin
        scalar_nxt = ctx_end.dot;
        sat_nxt    = ctx_end.dot_sat;
      end
      vva_pkg::OP_LEN: begin
        scalar_nxt = len_end[31] ? vva_pkg::MAX32 : len_end;
        sat_nxt    = len_end[31];
      end
      default: scalar_nxt = '0;
    endcase
    eq_nxt = (ctx_end.op == vva_pkg::OP_EQ || ctx_end.op == vva_pkg::OP_AEQ) &&
             ctx_end.lane[0].eq && ctx_end.lane[1].eq && ctx_end.lane[2].eq;
  end

  // output register
  logic signed [31:0] res_r [3];
  logic signed [31:0] scalar_r;
  logic               eq_r, dz_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_dl_r[CTX_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      res_r[2] <= res_nxt[2];
      scalar_r <= scalar_nxt;
      eq_r     <= eq_nxt;
      dz_r     <= dz_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_x     = res_r[0];
  assign out_ch.res_y     = res_r[1];
  assign out_ch.res_z     = res_r[2];
  assign out_ch.scalar    = scalar_r;
  assign out_ch.is_equal  = eq_r;
  assign out_ch.div_zero  = dz_r;
  assign out_ch.saturated = sat_r;

  // equality results carry no vector or scalar
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && eq_r |-> res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0 &&
                            scalar_r == '0)
    else $error("equality result with nonzero data");

  // divide by zero only comes from the vector divide
  a_dz_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> scalar_r == '0 && !eq_r)
    else $error("div_zero on a non-divide result");

  // scalar and vector results never appear together
  a_scalar_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && scalar_r != '0 |-> res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0)
    else $error("scalar and vector both nonzero");

  // a saturated scalar sits on a rail
  a_scalar_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r && scalar_r != '0 |->
      scalar_r == vva_pkg::MAX32 || scalar_r == vva_pkg::MIN32)
    else $error("saturated scalar off the rail");

endmodule

[tb/vva_alu_checker.sv]
// ----------------------------------------------------------------------------
// vva_alu_checker
// Watches the request and result channels of the vector ALU, computes the
// expected result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module vva_alu_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [vva_pkg::EPS_W-1:0] cfg_wdata,
  vva_in_if                         in_ch,
  vva_out_if                        out_ch,
  output int                        fail_count,
  output int                        pending
);

  typedef logic signed [vva_pkg::DW-1:0] word_t;
  typedef logic signed [127:0]           wide_t;

  typedef struct {
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t scalar;
    logic  is_equal;
    logic  div_zero;
    logic  saturated;
  } alu_result_t;

  alu_result_t                expected_results[$];
  logic [vva_pkg::EPS_W-1:0]  eps_q;

  function automatic word_t clip(input wide_t v, inout logic flag);
    if (v > wide_t'(vva_pkg::MAX32)) begin
      flag = 1'b1;
      return vva_pkg::MAX32;
    end
    if (v < wide_t'(vva_pkg::MIN32)) begin
      flag = 1'b1;
      return vva_pkg::MIN32;
    end
    return v[vva_pkg::DW-1:0];
  endfunction

  function automatic wide_t abs_w(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t floor_sqrt(input wide_t n_in);
    wide_t n, root, bit_w;
    n = n_in;
    root = 0;
    bit_w = wide_t'(1) <<< 64;
    while (bit_w > n) bit_w = bit_w >>> 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n = n - (root + bit_w);
        root = (root >>> 1) + bit_w;
      end else begin
        root = root >>> 1;
      end
      bit_w = bit_w >>> 2;
    end
    return root;
  endfunction

  function automatic alu_result_t alu_compute(input logic [3:0] op, input word_t a [3],
                                              input word_t b [3],
                                              input logic [vva_pkg::EPS_W-1:0] eps);
    alu_result_t r;
    wide_t       wa [3];
    wide_t       wb [3];
    wide_t       acc, len, lim, d;
    wide_t       one_q;
    logic        st, dz, eq;
    word_t       v [3];
    one_q = wide_t'(1) <<< FRAC_BITS;
    st = 1'b0;
    dz = 1'b0;
    eq = 1'b0;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = wide_t'(a[i]);
      wb[i] = wide_t'(b[i]);
      v[i] = '0;
    end
    case (op)
      vva_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) v[i] = clip(wa[i] + wb[i], st);
      vva_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) v[i] = clip(wa[i] - wb[i], st);
      vva_pkg::OP_MUL:
        for (int i = 0; i < 3; i++) v[i] = clip((wa[i] * wb[i]) >>> FRAC_BITS, st);
      vva_pkg::OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (wb[i] == 0) begin
            dz = 1'b1;
            v[i] = (wa[i] > 0) ? vva_pkg::MAX32 : ((wa[i] < 0) ? vva_pkg::MIN32 : '0);
          end else begin
            v[i] = clip((wa[i] * one_q) / wb[i], st);
          end
        end
      end
      vva_pkg::OP_MIN:
        for (int i = 0; i < 3; i++) v[i] = (a[i] < b[i]) ? a[i] : b[i];
      vva_pkg::OP_MAX:
        for (int i = 0; i < 3; i++) v[i] = (a[i] > b[i]) ? a[i] : b[i];
      // ceil(x) = -floor(-x)
      vva_pkg::OP_CEIL:
        for (int i = 0; i < 3; i++) v[i] = clip(-(((-wa[i]) >>> FRAC_BITS) * one_q), st);
      vva_pkg::OP_FLOOR:
        for (int i = 0; i < 3; i++) v[i] = clip((wa[i] >>> FRAC_BITS) * one_q, st);
      vva_pkg::OP_CROSS: begin
        v[0] = clip((wa[1] * wb[2] - wa[2] * wb[1]) >>> FRAC_BITS, st);
        v[1] = clip((wa[2] * wb[0] - wa[0] * wb[2]) >>> FRAC_BITS, st);
        v[2] = clip((wa[0] * wb[1] - wa[1] * wb[0]) >>> FRAC_BITS, st);
      end
      vva_pkg::OP_DOT: begin
        acc = (wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2]) >>> FRAC_BITS;
        acc = wide_t'(clip(acc, st));
      end
      vva_pkg::OP_LEN: begin
        acc = wide_t'(clip(floor_sqrt(wa[0] * wa[0] + wa[1] * wa[1] + wa[2] * wa[2]), st));
      end
      vva_pkg::OP_NORM: begin
        len = floor_sqrt(wa[0] * wa[0] + wa[1] * wa[1] + wa[2] * wa[2]);
        if (len != 0) begin
          for (int i = 0; i < 3; i++) v[i] = word_t'((wa[i] * one_q) / len);
        end
      end
      vva_pkg::OP_EQ: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      vva_pkg::OP_AEQ: begin
        eq = 1'b1;
        for (int i = 0; i < 3; i++) begin
          lim = one_q;
          if (abs_w(wa[i]) > lim) lim = abs_w(wa[i]);
          if (abs_w(wb[i]) > lim) lim = abs_w(wb[i]);
          d = abs_w(wa[i] - wb[i]);
          if (d * one_q > wide_t'({1'b0, eps}) * lim) eq = 1'b0;
        end
      end
      default: ;
    endcase
    r.res_x = v[0];
    r.res_y = v[1];
    r.res_z = v[2];
    r.scalar = acc[vva_pkg::DW-1:0];
    r.is_equal = eq;
    r.div_zero = dz;
    r.saturated = st;
    return r;
  endfunction

  task automatic report(input string what, input logic [vva_pkg::DW-1:0] got,
                        input logic [vva_pkg::DW-1:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    eps_q = vva_pkg::EPS_RESET;
  end

  always @(posedge clk) begin
    alu_result_t e;
    word_t       a [3];
    word_t       b [3];
    if (rst_n) begin
      if (cfg_we) begin
        eps_q <= cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        a = '{in_ch.a_x, in_ch.a_y, in_ch.a_z};
        b = '{in_ch.b_x, in_ch.b_y, in_ch.b_z};
        expected_results.push_back(alu_compute(in_ch.op, a, b, eps_q));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_ch.res_x, '0);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.res_x !== e.res_x) report("res_x", out_ch.res_x, e.res_x);
          if (out_ch.res_y !== e.res_y) report("res_y", out_ch.res_y, e.res_y);
          if (out_ch.res_z !== e.res_z) report("res_z", out_ch.res_z, e.res_z);
          if (out_ch.scalar !== e.scalar) report("scalar", out_ch.scalar, e.scalar);
          if (out_ch.is_equal !== e.is_equal)
            report("is_equal", vva_pkg::DW'(out_ch.is_equal), vva_pkg::DW'(e.is_equal));
          if (out_ch.div_zero !== e.div_zero)
            report("div_zero", vva_pkg::DW'(out_ch.div_zero), vva_pkg::DW'(e.div_zero));
          if (out_ch.saturated !== e.saturated)
            report("saturated", vva_pkg::DW'(out_ch.saturated), vva_pkg::DW'(e.saturated));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the vector ALU with directed corner requests and random requests
// over several epsilon settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY = 84;

  // opcodes with no operation behind them
  localparam logic [3:0] OP_SPARE_A = 4'd14;
  localparam logic [3:0] OP_SPARE_B = 4'd15;

  localparam logic [vva_pkg::DW-1:0] MAXV = vva_pkg::MAX32;
  localparam logic [vva_pkg::DW-1:0] MINV = vva_pkg::MIN32;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [vva_pkg::EPS_W-1:0] cfg_wdata;
  int                        fail_count;
  int                        pending;
  logic                      idle_on;
  int                        stall_cnt;

  vva_in_if  in_ch ();
  vva_out_if out_ch ();

  vec3_vector_alu_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  vva_alu_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** vec3_vector_alu_core: FAILED **");
    $finish;
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ch.ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [vva_pkg::DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return $urandom_range(0, 32'h000f_ffff);
      6: return -$urandom_range(0, 32'h000f_ffff);
      7: return 32'h7fff_0000 + $urandom_range(0, 32'hffff);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input logic [3:0] op,
                      input logic [vva_pkg::DW-1:0] ax, ay, az, bx, by, bz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.a_x <= ax;
    in_ch.a_y <= ay;
    in_ch.a_z <= az;
    in_ch.b_x <= bx;
    in_ch.b_y <= by;
    in_ch.b_z <= bz;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [vva_pkg::DW-1:0] bx, by, bz;
    logic [3:0]             op;
    // opcodes 14 and 15 are unused and must return zeros
    op = 4'($urandom_range(0, 15));
    bx = pick_value();
    by = pick_value();
    bz = pick_value();
    if ((op == vva_pkg::OP_EQ || op == vva_pkg::OP_AEQ) && $urandom_range(0, 1)) begin
      // near-equal pairs exercise the tolerance edge
      send(op, bx + $urandom_range(0, 3), by - $urandom_range(0, 3), bz, bx, by, bz);
    end else begin
      send(op, pick_value(), pick_value(), pick_value(), bx, by, bz);
    end
  endtask

  task automatic drain_and_write(input logic [vva_pkg::EPS_W-1:0] eps);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= eps;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [vva_pkg::EPS_W-1:0] eps_list [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    stall_cnt = 0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = vva_pkg::OP_ADD;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset epsilon
    send(vva_pkg::OP_ADD, MAXV, MINV, 32'h1, 32'h1, 32'hffff_ffff, 32'h2);
    send(vva_pkg::OP_SUB, MINV, MAXV, '0, 32'h1, 32'hffff_ffff, MINV);
    send(vva_pkg::OP_MUL, MAXV, MINV, 32'hffff_8000, MAXV, MINV, 32'h0001_8000);
    send(vva_pkg::OP_DIV, 32'h0003_0000, 32'hfffd_0000, '0, '0, '0, '0);
    send(vva_pkg::OP_DIV, MAXV, MINV, 32'h0001_0000, 32'h1, 32'h1, 32'hffff_ffff);
    send(vva_pkg::OP_MIN, MINV, MAXV, '0, MAXV, MINV, 32'h1);
    send(vva_pkg::OP_MAX, MINV, MAXV, '0, MAXV, MINV, 32'hffff_ffff);
    send(vva_pkg::OP_CEIL, MAXV, 32'h7fff_0001, MINV, '0, '0, '0);
    send(vva_pkg::OP_CEIL, 32'hffff_8000, 32'h0000_8000, 32'h0001_0000, '0, '0, '0);
    send(vva_pkg::OP_FLOOR, MAXV, MINV, 32'hffff_8000, '0, '0, '0);
    send(vva_pkg::OP_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV);
    send(vva_pkg::OP_CROSS, 32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0);
    send(vva_pkg::OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV);
    send(vva_pkg::OP_DOT, 32'h0002_0000, 32'h0003_0000, 32'hffff_ffff, 32'h1, 32'h1, 32'h1);
    send(vva_pkg::OP_LEN, MINV, MINV, MINV, '0, '0, '0);
    send(vva_pkg::OP_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0);
    send(vva_pkg::OP_NORM, '0, '0, '0, '0, '0, '0);
    send(vva_pkg::OP_NORM, MINV, MAXV, 32'h1, '0, '0, '0);
    send(vva_pkg::OP_EQ, MAXV, MINV, '0, MAXV, MINV, '0);
    send(vva_pkg::OP_EQ, MAXV, MINV, '0, MAXV, MINV, 32'h1);
    send(vva_pkg::OP_AEQ, 32'h0001_0000, '0, MINV, 32'h0001_0001, '0, MINV);
    send(vva_pkg::OP_AEQ, MAXV, MINV, '0, MINV, MAXV, '0);
    send(OP_SPARE_A, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send(OP_SPARE_B, MINV, MINV, MINV, MINV, MINV, MINV);
    repeat (60) send_random();

    eps_list = '{17'd0, 17'd65536, 17'd6554, 17'd1, 17'($urandom_range(0, 65536))};
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(eps_list[ph]);
      if (ph == 4) idle_on = 1'b0;
      for (int k = 0; k < 90; k++) begin
        if (k % 10 == 0) begin
          send(vva_pkg::OP_AEQ, 32'h0001_0000, 32'h0001_0000, '0, 32'h0001_0001,
               32'h0001_0000, 32'h0000_0001);
        end else begin
          send_random();
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("** vec3_vector_alu_core: PASSED **");
    end else begin
      $display("** vec3_vector_alu_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/vva_pkg.sv
hw/rtl/vva_in_if.sv
hw/rtl/vva_out_if.sv
hw/rtl/vva_lane.sv
hw/rtl/vva_sqrt.sv
hw/rtl/vva_div.sv
hw/rtl/vec3_vector_alu_core.sv
tb/vva_alu_checker.sv
tb/tb.sv
